[rtl/dllm_pkg.sv]
// dllm_pkg: shared types and constants of the decaying load and latency monitor
// used by the channel interfaces, the top level and the checker
`timescale 1ns / 1ps

package dllm_pkg;

   localparam int FUNC_W    = 2;
   localparam int SECONDS_W = 32;
   localparam int LAT_W     = 16;
   localparam int COUNT_W   = 32;
   localparam int SUM_W     = 48;
   localparam int RATE_W    = 30;
   localparam int RESULT_W  = 32;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 32;

   localparam int STALE_LIMIT_DEF = 8;

   // bits of the func field
   localparam int FUNC_COUNT_BIT = 0;
   localparam int FUNC_LAT_BIT   = 1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_AVG  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_PEAK = 1'b1;

   localparam logic [COUNT_W-1:0]  MAX_COUNT  = '1;
   localparam logic [SUM_W-1:0]    MAX_SUM    = '1;
   localparam logic [RESULT_W-1:0] MAX_RESULT = '1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DECAY,
      ST_APPLY,
      ST_MUL,
      ST_FLOOR,
      ST_DIV_SETUP,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

[rtl/dllm_if.sv]
// dllm_if: valid/ready channel interfaces for requests, responses and csr writes
// depends on dllm_pkg for field widths
`timescale 1ns / 1ps

interface dllm_req_if import dllm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [FUNC_W-1:0]    func;
   logic [SECONDS_W-1:0] now_seconds;
   logic [LAT_W-1:0]     latency;

   modport source (output valid, func, now_seconds, latency, input ready);
   modport sink   (input valid, func, now_seconds, latency, output ready);
endinterface

interface dllm_rsp_if import dllm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [RATE_W-1:0]   count_rate;
   logic [RESULT_W-1:0] latency_avg;
   logic [RESULT_W-1:0] latency_peak;
   logic                over_target;

   modport source (output valid, count_rate, latency_avg, latency_peak, over_target,
                   input ready);
   modport sink   (input valid, count_rate, latency_avg, latency_peak, over_target,
                   output ready);
endinterface

interface dllm_csr_if import dllm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/decaying_load_latency_monitor.sv]
// decaying_load_latency_monitor: event rate and latency tracker with quarter decay per second
// depends on dllm_pkg and the channel interfaces in dllm_if
`timescale 1ns / 1ps

// Each request on req_ch carries func, now_seconds and latency. The block first
// catches up the decay of its sums to now_seconds, then adds the count and/or
// latency event, and returns exactly one response on rsp_ch: count_rate,
// latency_avg, latency_peak and over_target.
// csr_ch writes target_avg (index 0) and target_peak (index 1); it is always
// ready and should only be used while no request is in flight.
// A request is held for its whole processing: req_ch.ready is high only while
// the sequencer is idle. After acceptance the time is checked, one decay step
// runs per elapsed second (at most STALE_LIMIT), the event is applied, a latency
// event adds a multiply and a peak floor step, and, when latency events are
// held, the 32-step shared restoring divider produces average and peak together;
// the next request can be accepted the cycle after the result is registered.
// The response sits in an output register; a new request is accepted while it
// waits, and the sequencer only holds in its final step if the previous
// response has still not been taken.
// Synchronous reset clears all sums, the last update second (to zero), the
// targets and the response valid.
module decaying_load_latency_monitor import dllm_pkg::*; #(
   parameter int STALE_LIMIT = STALE_LIMIT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   dllm_req_if.sink     req_ch,
   dllm_rsp_if.source   rsp_ch,
   dllm_csr_if.sink     csr_ch
);

   localparam int STEP_W = $clog2(STALE_LIMIT + 1);
   localparam int DIV_STEPS = RESULT_W;
   localparam int CNT_W = $clog2(DIV_STEPS);
   localparam int HI_W = SUM_W - 2 - RESULT_W;

   state_type state_ff, state_in;

   logic [FUNC_W-1:0]    func_ff, func_in;
   logic [SECONDS_W-1:0] now_ff, now_in;
   logic [LAT_W-1:0]     lat_ff, lat_in;

   logic [COUNT_W-1:0]   dc_ff, dc_in;
   logic [COUNT_W-1:0]   ec_ff, ec_in;
   logic [SUM_W-1:0]     ls_ff, ls_in;
   logic [SUM_W-1:0]     ps_ff, ps_in;
   logic [SECONDS_W-1:0] last_ff, last_in;
   logic [STEP_W-1:0]    steps_ff, steps_in;
   logic [SUM_W-1:0]     prod_ff, prod_in;

   logic [RESULT_W-1:0]  rem_a_ff, rem_a_in, rem_b_ff, rem_b_in;
   logic [RESULT_W-1:0]  quo_a_ff, quo_a_in, quo_b_ff, quo_b_in;
   logic                 sat_a_ff, sat_a_in, sat_b_ff, sat_b_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic [CSR_DAT_W-1:0] target_avg_ff, target_avg_in;
   logic [CSR_DAT_W-1:0] target_peak_ff, target_peak_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]    rate_ff, rate_in;
   logic [RESULT_W-1:0]  avg_ff, avg_in;
   logic [RESULT_W-1:0]  peak_ff, peak_in;
   logic                 over_ff, over_in;

   logic req_accept;
   logic rsp_load;
   logic same_time;
   logic stale;
   logic div_last;

   logic [SECONDS_W:0]   diff_time;
   logic [COUNT_W:0]     dc_plus3, ec_plus3;
   logic [COUNT_W:0]     div_t_a, div_t_b;
   logic                 div_ge_a, div_ge_b;
   logic [SUM_W:0]       ls_add, ps_add;
   logic [SUM_W+1:0]     floor_raw;
   logic [SUM_W-1:0]     floor_peak;
   logic                 avg_over, peak_over;

   // ---------------- control ----------------

   assign req_accept = req_ch.valid && req_ch.ready;
   assign same_time  = (now_ff == last_ff);
   assign diff_time  = {1'b0, now_ff} - {1'b0, last_ff};
   // backwards in time or beyond the stale window
   assign stale      = (now_ff < last_ff) ||
                       ({1'b0, now_ff} > ({1'b0, last_ff} + (SECONDS_W+1)'(STALE_LIMIT)));
   assign div_last   = (cnt_ff == CNT_W'(DIV_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (same_time || stale) state_in = ST_APPLY;
            else state_in = ST_DECAY;
         end
         ST_DECAY: begin
            if (steps_ff == STEP_W'(1)) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (func_ff[FUNC_LAT_BIT]) state_in = ST_MUL;
            else state_in = ST_DIV_SETUP;
         end
         ST_MUL:   state_in = ST_FLOOR;
         ST_FLOOR: state_in = ST_DIV_SETUP;
         ST_DIV_SETUP: begin
            if (ec_ff == '0) state_in = ST_DONE;
            else state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      rsp_load     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);
   end

   // ---------------- datapath ----------------

   assign dc_plus3 = {1'b0, dc_ff} + (COUNT_W+1)'(3);
   assign ec_plus3 = {1'b0, ec_ff} + (COUNT_W+1)'(3);
   assign ls_add   = {1'b0, ls_ff} + (SUM_W+1)'(lat_ff);
   assign ps_add   = {1'b0, ps_ff} + (SUM_W+1)'(lat_ff);

   assign floor_raw  = {prod_ff, 2'b00};
   assign floor_peak = (floor_raw[SUM_W+1:SUM_W] != 2'b00) ? MAX_SUM : floor_raw[SUM_W-1:0];

   // shared divider step, both lanes use the event count as divisor
   assign div_t_a  = {rem_a_ff, quo_a_ff[RESULT_W-1]};
   assign div_t_b  = {rem_b_ff, quo_b_ff[RESULT_W-1]};
   assign div_ge_a = (div_t_a >= {1'b0, ec_ff});
   assign div_ge_b = (div_t_b >= {1'b0, ec_ff});

   assign avg_over  = (target_avg_ff != '0) && (sat_a_ff || (quo_a_ff > target_avg_ff));
   assign peak_over = (target_peak_ff != '0) && (sat_b_ff || (quo_b_ff > target_peak_ff));

   always_comb begin
      func_in  = func_ff;
      now_in   = now_ff;
      lat_in   = lat_ff;
      dc_in    = dc_ff;
      ec_in    = ec_ff;
      ls_in    = ls_ff;
      ps_in    = ps_ff;
      last_in  = last_ff;
      steps_in = steps_ff;
      prod_in  = prod_ff;
      rem_a_in = rem_a_ff;
      rem_b_in = rem_b_ff;
      quo_a_in = quo_a_ff;
      quo_b_in = quo_b_ff;
      sat_a_in = sat_a_ff;
      sat_b_in = sat_b_ff;
      cnt_in   = cnt_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               func_in = req_ch.func;
               now_in  = req_ch.now_seconds;
               // latency of one counts as zero
               lat_in  = (req_ch.latency == LAT_W'(1)) ? '0 : req_ch.latency;
            end
         end
         ST_CHECK: begin
            if (!same_time) begin
               last_in = now_ff;
               if (stale) begin
                  dc_in = '0;
                  ec_in = '0;
                  ls_in = '0;
                  ps_in = '0;
               end else begin
                  steps_in = diff_time[STEP_W-1:0];
               end
            end
         end
         ST_DECAY: begin
            dc_in    = dc_ff - COUNT_W'(dc_plus3[COUNT_W:2]);
            ec_in    = ec_ff - COUNT_W'(ec_plus3[COUNT_W:2]);
            ls_in    = ls_ff - (ls_ff >> 2);
            ps_in    = ps_ff - (ps_ff >> 2);
            steps_in = steps_ff - STEP_W'(1);
         end
         ST_APPLY: begin
            if (func_ff[FUNC_COUNT_BIT] && (dc_ff != MAX_COUNT)) dc_in = dc_ff + COUNT_W'(1);
            if (func_ff[FUNC_LAT_BIT]) begin
               if (ec_ff != MAX_COUNT) ec_in = ec_ff + COUNT_W'(1);
               ls_in = ls_add[SUM_W] ? MAX_SUM : ls_add[SUM_W-1:0];
               ps_in = ps_add[SUM_W] ? MAX_SUM : ps_add[SUM_W-1:0];
            end
         end
         ST_MUL: begin
            prod_in = SUM_W'(ec_ff * lat_ff);
         end
         ST_FLOOR: begin
            if (ps_ff < floor_peak) ps_in = floor_peak;
         end
         ST_DIV_SETUP: begin
            // divide sum/4 by the event count; a high part at or above the
            // divisor means the quotient does not fit in 32 bits
            cnt_in   = '0;
            sat_a_in = (ec_ff != '0) && ({{(COUNT_W-HI_W){1'b0}}, ls_ff[SUM_W-1 -: HI_W]} >= ec_ff);
            sat_b_in = (ec_ff != '0) && ({{(COUNT_W-HI_W){1'b0}}, ps_ff[SUM_W-1 -: HI_W]} >= ec_ff);
            rem_a_in = sat_a_in ? '0 : RESULT_W'(ls_ff[SUM_W-1 -: HI_W]);
            rem_b_in = sat_b_in ? '0 : RESULT_W'(ps_ff[SUM_W-1 -: HI_W]);
            quo_a_in = (ec_ff == '0 || sat_a_in) ? '0 : ls_ff[RESULT_W+1:2];
            quo_b_in = (ec_ff == '0 || sat_b_in) ? '0 : ps_ff[RESULT_W+1:2];
         end
         ST_DIV: begin
            rem_a_in = div_ge_a ? RESULT_W'(div_t_a - {1'b0, ec_ff}) : div_t_a[RESULT_W-1:0];
            rem_b_in = div_ge_b ? RESULT_W'(div_t_b - {1'b0, ec_ff}) : div_t_b[RESULT_W-1:0];
            quo_a_in = {quo_a_ff[RESULT_W-2:0], div_ge_a};
            quo_b_in = {quo_b_ff[RESULT_W-2:0], div_ge_b};
            cnt_in   = cnt_ff + CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rate_in      = rate_ff;
      avg_in       = avg_ff;
      peak_in      = peak_ff;
      over_in      = over_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rate_in      = dc_ff[COUNT_W-1:2];
         avg_in       = sat_a_ff ? MAX_RESULT : quo_a_ff;
         peak_in      = sat_b_ff ? MAX_RESULT : quo_b_ff;
         over_in      = avg_over || peak_over;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      target_avg_in  = target_avg_ff;
      target_peak_in = target_peak_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_TARGET_AVG:  target_avg_in  = csr_ch.data;
            CSR_TARGET_PEAK: target_peak_in = csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   assign csr_ch.ready        = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.count_rate   = rate_ff;
   assign rsp_ch.latency_avg  = avg_ff;
   assign rsp_ch.latency_peak = peak_ff;
   assign rsp_ch.over_target  = over_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         dc_ff          <= '0;
         ec_ff          <= '0;
         ls_ff          <= '0;
         ps_ff          <= '0;
         last_ff        <= '0;
         target_avg_ff  <= '0;
         target_peak_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         dc_ff          <= dc_in;
         ec_ff          <= ec_in;
         ls_ff          <= ls_in;
         ps_ff          <= ps_in;
         last_ff        <= last_in;
         target_avg_ff  <= target_avg_in;
         target_peak_ff <= target_peak_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      now_ff   <= now_in;
      lat_ff   <= lat_in;
      steps_ff <= steps_in;
      prod_ff  <= prod_in;
      rem_a_ff <= rem_a_in;
      rem_b_ff <= rem_b_in;
      quo_a_ff <= quo_a_in;
      quo_b_ff <= quo_b_in;
      sat_a_ff <= sat_a_in;
      sat_b_ff <= sat_b_in;
      cnt_ff   <= cnt_in;
      rate_ff  <= rate_in;
      avg_ff   <= avg_in;
      peak_ff  <= peak_in;
      over_ff  <= over_in;
   end

endmodule

[rtl/dllm_checker.sv]
// dllm_checker: port-level assertions for decaying_load_latency_monitor
// depends on dllm_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module dllm_checker import dllm_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [RATE_W-1:0]   count_rate,
   input logic [RESULT_W-1:0] latency_avg,
   input logic [RESULT_W-1:0] latency_peak,
   input logic                over_target
);

   // a request is held until its response is produced, no back-to-back accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous request still in progress");

   // over target needs a nonzero average or peak
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && over_target |-> (latency_avg != '0 || latency_peak != '0))
      else $error("over_target set with zero average and peak");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(count_rate) &&
         $stable(latency_avg) && $stable(latency_peak) && $stable(over_target))
      else $error("stalled response dropped or changed");

endmodule

bind decaying_load_latency_monitor dllm_checker u_dllm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .count_rate   (rsp_ch.count_rate),
   .latency_avg  (rsp_ch.latency_avg),
   .latency_peak (rsp_ch.latency_peak),
   .over_target  (rsp_ch.over_target)
);
